### rtl/core/stq_pkg.sv
// package for the sorted timer queue: widths, opcodes, status codes, control structs
// no dependencies
package stq_pkg;
  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned IV_BITS = 32;
  localparam int unsigned ID_BITS = 4;
  localparam int unsigned IDX_BITS = $clog2(TIMER_SLOTS);
  localparam int unsigned CNT_BITS = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned MAX_FIRES = 16;
  localparam int unsigned FIRE_BITS = $clog2(MAX_FIRES + 1);

  typedef logic [1:0] op_t;
  localparam op_t OP_ARM = 2'd0;
  localparam op_t OP_CANCEL = 2'd1;
  localparam op_t OP_TICK = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_DUP = 2'd3;

  // datapath commands
  typedef struct packed {
    logic load;        // capture request fields
    logic clr_scan;    // clear find/position scan results
    logic scan;        // compare entry at scan index
    logic shift_up;    // move slot i-1 to slot i
    logic shift_down;  // move slot i+1 to slot i
    logic write_new;   // write the pending timer at the insert position
    logic take_head;   // latch head into fire registers
    logic cnt_inc;
    logic cnt_dec;
    logic [IDX_BITS-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic [IDX_BITS-1:0] found_idx;
    logic pos_done;    // insert position fixed (first greater deadline seen)
    logic [IDX_BITS-1:0] pos_idx;
    logic head_due;
    logic head_periodic;
    logic [CNT_BITS-1:0] count;
  } dp_sts_t;
endpackage

### rtl/core/stq_if.sv
// valid/ready channel carrying a request or result payload
// depends on nothing; payload type given as a type parameter
interface stq_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sorted_timer_queue_top.sv
// sorted timer queue top level: request and result channels, controller and datapath
// depends on stq_pkg, stq_if, stq_ctrl, stq_datapath
//
// Holds up to 16 timers in deadline order. Arm inserts after equal deadlines, cancel
// removes by id, tick fires due head timers (up to 16 results, last marks the final
// one) and re-arms periodic ones at now+interval, saturated. An arm or cancel takes a
// full scan of the 16 slots and, unless refused, then moves one slot a cycle to open or
// close a gap before its result is offered. A tick with nothing due answers with no
// fired timer; each fired one-shot timer costs a pop shift and each re-armed timer a
// pop shift, a second scan and an insert shift, plus any result stall. One request at
// a time.
module sorted_timer_queue_top import stq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  stq_if.sink   req,
  stq_if.source res
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [ID_BITS-1:0] fire_id;
  logic [TIME_BITS-1:0] head_dl;
  status_t status;
  logic fired, rearm, last;

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .op_i(req.data.op),
    .cmd_o(cmd), .sts_i(sts),
    .res_valid_o(res.valid), .res_ready_i(res.ready),
    .res_status_o(status), .res_fired_o(fired), .res_rearm_o(rearm), .res_last_o(last)
  );

  stq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .id_i(req.data.timer_id), .deadline_i(req.data.deadline_ms),
    .interval_i(req.data.interval_ms), .now_i(req.data.now_ms),
    .sts_o(sts), .fire_id_o(fire_id), .head_dl_o(head_dl)
  );

  assign res.data.status = status;
  assign res.data.fired = fired;
  assign res.data.fired_id = fired ? fire_id : '0;
  assign res.data.rearmed = rearm & fired;
  assign res.data.next_deadline = head_dl;
  assign res.data.queue_empty = (sts.count == '0);
  assign res.data.last = last;

  a_req_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready) else $error("request taken while busy");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CNT_BITS'(TIMER_SLOTS)) else $error("armed count overflow");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && res.valid)) else $error("result pending while idle");
endmodule

### rtl/core/stq_datapath.sv
// timer slot storage, request registers, comparisons and re-arm arithmetic
// depends on stq_pkg
module stq_datapath import stq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [ID_BITS-1:0]   id_i,
  input  logic [TIME_BITS-1:0] deadline_i,
  input  logic [IV_BITS-1:0]   interval_i,
  input  logic [TIME_BITS-1:0] now_i,
  output dp_sts_t              sts_o,
  output logic [ID_BITS-1:0]   fire_id_o,
  output logic [TIME_BITS-1:0] head_dl_o
);
  logic [TIME_BITS-1:0] dl_q [TIMER_SLOTS];
  logic [IV_BITS-1:0]   iv_q [TIMER_SLOTS];
  logic [ID_BITS-1:0]   own_q [TIMER_SLOTS];
  logic [CNT_BITS-1:0]  cnt_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] new_dl_q, now_q;
  logic [IV_BITS-1:0]   new_iv_q;
  logic                 found_q, pos_q;
  logic [IDX_BITS-1:0]  fidx_q, pidx_q;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] rearm_dl;
  logic                 in_range;

  assign sum = {1'b0, now_q} + {{(TIME_BITS + 1 - IV_BITS){1'b0}}, iv_q[0]};
  // saturate re-arm time at the largest time value
  assign rearm_dl = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign in_range = ({1'b0, cmd_i.idx} < cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
      pos_q   <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      else if (cmd_i.cnt_dec) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.clr_scan) begin
        found_q <= 1'b0;
        pos_q   <= 1'b0;
      end else if (cmd_i.scan && in_range) begin
        if (!found_q && own_q[cmd_i.idx] == id_q) found_q <= 1'b1;
        if (!pos_q && dl_q[cmd_i.idx] > new_dl_q) pos_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q     <= id_i;
      new_dl_q <= deadline_i;
      new_iv_q <= interval_i;
      now_q    <= now_i;
    end
    if (cmd_i.take_head) begin
      id_q     <= own_q[0];
      new_iv_q <= iv_q[0];
      new_dl_q <= rearm_dl;
    end
    if (cmd_i.clr_scan) begin
      fidx_q <= '0;
      // default insert position is the end of the list as it stands after this cycle
      pidx_q <= cmd_i.cnt_dec ? IDX_BITS'(cnt_q - 1'b1) : IDX_BITS'(cnt_q);
    end else if (cmd_i.scan && in_range) begin
      if (!found_q && own_q[cmd_i.idx] == id_q) fidx_q <= cmd_i.idx;
      if (!pos_q && dl_q[cmd_i.idx] > new_dl_q) pidx_q <= cmd_i.idx;
    end
    if (cmd_i.shift_up) begin
      dl_q[cmd_i.idx]  <= dl_q[cmd_i.idx - 1'b1];
      iv_q[cmd_i.idx]  <= iv_q[cmd_i.idx - 1'b1];
      own_q[cmd_i.idx] <= own_q[cmd_i.idx - 1'b1];
    end else if (cmd_i.shift_down) begin
      dl_q[cmd_i.idx]  <= dl_q[cmd_i.idx + 1'b1];
      iv_q[cmd_i.idx]  <= iv_q[cmd_i.idx + 1'b1];
      own_q[cmd_i.idx] <= own_q[cmd_i.idx + 1'b1];
    end else if (cmd_i.write_new) begin
      dl_q[cmd_i.idx]  <= new_dl_q;
      iv_q[cmd_i.idx]  <= new_iv_q;
      own_q[cmd_i.idx] <= id_q;
    end
  end

  assign sts_o.found = found_q;
  assign sts_o.found_idx = fidx_q;
  assign sts_o.pos_done = pos_q;
  assign sts_o.pos_idx = pidx_q;
  assign sts_o.head_due = (cnt_q != '0) && (dl_q[0] <= now_q);
  assign sts_o.head_periodic = (iv_q[0] != '0);
  assign sts_o.count = cnt_q;
  assign fire_id_o = id_q;
  assign head_dl_o = (cnt_q == '0) ? '0 : dl_q[0];
endmodule

### rtl/core/stq_ctrl.sv
// sequencer for arm, cancel and tick: slot scans, shifts and result requests
// depends on stq_pkg
module stq_ctrl import stq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  op_t                 op_i,
  output dp_cmd_t             cmd_o,
  input  dp_sts_t             sts_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output status_t             res_status_o,
  output logic                res_fired_o,
  output logic                res_rearm_o,
  output logic                res_last_o
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_SHUP   = 9'b000001000,
    S_SHDN   = 9'b000010000,
    S_TCHK   = 9'b000100000,
    S_TPOP   = 9'b001000000,
    S_RES    = 9'b010000000,
    S_TWAIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  op_t op_q, op_d;
  logic [IDX_BITS-1:0] idx_q, idx_d;
  logic [CNT_BITS-1:0] budget_q, budget_d;
  logic [FIRE_BITS-1:0] fires_q, fires_d;
  status_t st_q, st_d;
  logic fired_q, fired_d, rearm_q, rearm_d, last_q, last_d, reins_q, reins_d;
  logic scan_end;

  assign scan_end = ({1'b0, idx_q} + 1'b1) >= {1'b0, IDX_BITS'(TIMER_SLOTS - 1)} + 1'b1;

  always_comb begin
    state_d = state_q; op_d = op_q; idx_d = idx_q; budget_d = budget_q;
    fires_d = fires_q; st_d = st_q; fired_d = fired_q; rearm_d = rearm_q;
    last_d = last_q; reins_d = reins_q;
    cmd_o = '0;
    cmd_o.idx = idx_q;
    in_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_RES);
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        cmd_o.clr_scan = 1'b1;
        op_d = op_i;
        idx_d = '0;
        fired_d = 1'b0; rearm_d = 1'b0; last_d = 1'b1; st_d = ST_OK;
        reins_d = 1'b0;
        if (op_i == OP_TICK) begin
          budget_d = sts_i.count;
          fires_d = '0;
          state_d = S_TWAIT;
        end else if (op_i == OP_ARM || op_i == OP_CANCEL) state_d = S_SCAN;
        else state_d = S_RES;
      end
      S_TWAIT: state_d = S_TCHK;
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        idx_d = idx_q + 1'b1;
        if (scan_end) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (reins_q) begin
          idx_d = IDX_BITS'(sts_i.count);
          state_d = S_SHUP;
        end else if (op_q == OP_ARM) begin
          if (sts_i.found) begin st_d = ST_DUP; state_d = S_RES; end
          else if (sts_i.count == CNT_BITS'(TIMER_SLOTS)) begin
            st_d = ST_FULL; state_d = S_RES;
          end else begin
            idx_d = IDX_BITS'(sts_i.count);
            state_d = S_SHUP;
          end
        end else begin
          if (!sts_i.found) begin st_d = ST_NOT_FOUND; state_d = S_RES; end
          else begin
            idx_d = sts_i.found_idx;
            state_d = S_SHDN;
          end
        end
      end
      // open a gap at the insert position, then write the new timer
      S_SHUP: begin
        if (idx_q == sts_i.pos_idx) begin
          cmd_o.write_new = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d = S_RES;
        end else begin
          cmd_o.shift_up = 1'b1;
          idx_d = idx_q - 1'b1;
        end
      end
      // close the gap left by a removed timer
      S_SHDN: begin
        if ({1'b0, idx_q} + 1'b1 >= sts_i.count) begin
          cmd_o.cnt_dec = 1'b1;
          if (reins_q || fired_q) begin
            if (sts_i.head_periodic && rearm_q) begin
              cmd_o.clr_scan = 1'b1;
              idx_d = '0;
              reins_d = 1'b1;
              state_d = S_SCAN;
            end else state_d = S_RES;
          end else state_d = S_RES;
        end else begin
          cmd_o.shift_down = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_TCHK: begin
        if (budget_q != '0 && fires_q != FIRE_BITS'(MAX_FIRES) && sts_i.head_due) begin
          cmd_o.take_head = 1'b1;
          budget_d = budget_q - 1'b1;
          fires_d = fires_q + 1'b1;
          fired_d = 1'b1;
          rearm_d = sts_i.head_periodic;
          idx_d = '0;
          state_d = S_TPOP;
        end else if (fires_q == '0) begin
          fired_d = 1'b0; last_d = 1'b1; state_d = S_RES;
        end else state_d = S_IDLE;
      end
      S_TPOP: begin
        // head is removed; re-insert if periodic after shift completes
        if ({1'b0, idx_q} + 1'b1 >= sts_i.count) begin
          cmd_o.cnt_dec = 1'b1;
          if (rearm_q) begin
            cmd_o.clr_scan = 1'b1;
            idx_d = '0;
            reins_d = 1'b1;
            state_d = S_SCAN;
          end else state_d = S_RES;
        end else begin
          cmd_o.shift_down = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_RES: begin
        if (op_q == OP_TICK && fired_q) last_d = 1'b0;
        if (res_ready_i) begin
          reins_d = 1'b0;
          state_d = (op_q == OP_TICK && fired_q) ? S_TCHK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // last for a fired result is known only once the next head is checked
  logic more;
  assign more = (budget_q != '0) && (fires_q != FIRE_BITS'(MAX_FIRES)) && sts_i.head_due;

  assign res_status_o = st_q;
  assign res_fired_o = fired_q;
  assign res_rearm_o = rearm_q;
  assign res_last_o = (op_q == OP_TICK && fired_q) ? !more : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= OP_ARM;
      idx_q <= '0;
      budget_q <= '0;
      fires_q <= '0;
      st_q <= ST_OK;
      fired_q <= 1'b0;
      rearm_q <= 1'b0;
      last_q <= 1'b0;
      reins_q <= 1'b0;
    end else begin
      state_q <= (state_d == S_IDLE && state_q == S_TCHK) ? S_IDLE : state_d;
      op_q <= op_d;
      idx_q <= idx_d;
      budget_q <= budget_d;
      fires_q <= fires_d;
      st_q <= st_d;
      fired_q <= fired_d;
      rearm_q <= rearm_d;
      last_q <= last_d;
      reins_q <= reins_d;
    end
  end
endmodule
